[rtl/core/drt_pkg.sv]
// Dirty region tracker package: table geometry, action and config codes, state enum, divider structs.
// No dependencies.
package drt_pkg;
  localparam int NUM_REGIONS = 8;
  localparam int COORD_BITS = 11;
  localparam int SIZE_BITS = COORD_BITS + 1;
  localparam int SLOT_BITS = 3;
  localparam int SEXT_BITS = SIZE_BITS + 2;
  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};
  localparam logic [SIZE_BITS-1:0] SIZE_MAX = {SIZE_BITS{1'b1}};

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_MERGE = 2'd1,
    ACT_READ = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    CFG_SW = 2'd0,
    CFG_SH = 2'd1,
    CFG_TAE = 2'd2,
    CFG_TS = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIVX,
    ST_DIVW,
    ST_DIVY,
    ST_DIVH,
    ST_FIND,
    ST_PAIR,
    ST_LIST
  } state_t;

  typedef struct packed {
    logic start;
    logic [SEXT_BITS-1:0] num;
    logic [7:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [SEXT_BITS-1:0] quot;
    logic [7:0] rem;
  } div_rsp_t;
endpackage

[rtl/core/dirty_region_tracker.sv]
// Dirty region tracker top level: sequencer, region table, shared divider.
// Depends on drt_pkg and drt_divider.
//
// Takes one request when start is high and busy is low. An add with tile
// alignment holds busy through four serial tile divisions, each of which
// loads the divider, waits for the quotient bits and takes the result, and
// then through the slot scan. With alignment off it holds busy for the slot
// scan only. Merge holds busy for one pair test per slot pair and then lists
// each active entry (one empty entry when the table is empty); read only
// lists. Clear leaves busy low. The final result of a request shows up in
// the same cycle as busy drops. Results appear for one cycle with out_valid;
// the receiver cannot stall.
module dirty_region_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic signed [11:0] in_x,
  input  logic signed [11:0] in_y,
  input  logic [10:0] in_w,
  input  logic [10:0] in_h,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data,
  output logic        out_valid,
  output logic [2:0]  out_slot,
  output logic [10:0] out_rect_x,
  output logic [10:0] out_rect_y,
  output logic [11:0] out_rect_w,
  output logic [11:0] out_rect_h,
  output logic        out_active,
  output logic        out_full_merge,
  output logic [4:0]  out_merged_count,
  output logic        out_last
);
  import drt_pkg::*;

  localparam int S = SEXT_BITS;

  logic [10:0] sw_r, sh_r;
  logic tae_r;
  logic [7:0] ts_r;

  logic [COORD_BITS-1:0] left_r [NUM_REGIONS];
  logic [COORD_BITS-1:0] top_r [NUM_REGIONS];
  logic [SIZE_BITS-1:0] wid_r [NUM_REGIONS];
  logic [SIZE_BITS-1:0] hgt_r [NUM_REGIONS];
  logic [NUM_REGIONS-1:0] valid_r;
  logic dirty_pending_r;

  state_t state_r, state_nxt;
  logic [SLOT_BITS-1:0] i_r, j_r;
  logic [4:0] cnt_r;
  logic [S-1:0] ax_r, ay_r, aw_r, ah_r;
  logic first_r;
  logic div_wait_r;

  div_req_t dreq;
  div_rsp_t drsp;

  drt_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  // Clipping of a new request.
  logic signed [S-1:0] cx, cy, cw, ch;
  always_comb begin
    cx = in_x[11] ? '0 : S'(in_x);
    cy = in_y[11] ? '0 : S'(in_y);
    cw = S'(in_w);
    ch = S'(in_h);
    if (cx + cw > S'(sw_r)) cw = S'(sw_r) - cx;
    if (cy + ch > S'(sh_r)) ch = S'(sh_r) - cy;
    if (cw < 0) cw = '0;
    if (ch < 0) ch = '0;
  end

  // Saturation to the table widths.
  function automatic logic [COORD_BITS-1:0] sat_c(input logic [S-1:0] v);
    return (v[S-1]) ? '0 : ((v > S'(COORD_MAX)) ? COORD_MAX : v[COORD_BITS-1:0]);
  endfunction
  function automatic logic [SIZE_BITS-1:0] sat_s(input logic [S-1:0] v);
    return (v[S-1]) ? '0 : ((v > S'(SIZE_MAX)) ? SIZE_MAX : v[SIZE_BITS-1:0]);
  endfunction

  logic align;
  assign align = tae_r && (ts_r != 8'd0);

  // Aligned values from the divider.
  logic [S-1:0] prod_dn, prod_up;
  assign prod_dn = S'(drsp.quot * ts_r);
  assign prod_up = (drsp.rem == 8'd0) ? prod_dn : S'(prod_dn + S'(ts_r));

  // Free slot search.
  logic found;
  logic [SLOT_BITS-1:0] free_idx;
  always_comb begin
    found = 1'b0;
    free_idx = '0;
    for (int k = NUM_REGIONS - 1; k >= 0; k--) begin
      if (!valid_r[k]) begin
        found = 1'b1;
        free_idx = SLOT_BITS'(k);
      end
    end
  end

  // Pair overlap test on the shared compare path.
  logic [S-1:0] pax, pay, par, pab, pbx, pby, pbr, pbb;
  logic ovl;
  always_comb begin
    pax = S'(left_r[i_r]);
    pay = S'(top_r[i_r]);
    par = pax + S'(wid_r[i_r]);
    pab = pay + S'(hgt_r[i_r]);
    pbx = S'(left_r[j_r]);
    pby = S'(top_r[j_r]);
    pbr = pbx + S'(wid_r[j_r]);
    pbb = pby + S'(hgt_r[j_r]);
    ovl = valid_r[i_r] && valid_r[j_r] &&
          !(pbx >= par || pbr <= pax || pby >= pab || pbb <= pay);
  end

  // Union with slot 0 for a full table.
  logic [S-1:0] ux, uy, ur, ub;
  always_comb begin
    ux = (S'(left_r[0]) < ax_r) ? S'(left_r[0]) : ax_r;
    uy = (S'(top_r[0]) < ay_r) ? S'(top_r[0]) : ay_r;
    ur = S'(left_r[0]) + S'(wid_r[0]);
    ub = S'(top_r[0]) + S'(hgt_r[0]);
    if (ax_r + aw_r > ur) ur = ax_r + aw_r;
    if (ay_r + ah_r > ub) ub = ay_r + ah_r;
  end

  // Next active slot for listing (from i_r).
  logic lfound, lmore;
  logic [SLOT_BITS-1:0] lidx;
  always_comb begin
    lfound = 1'b0;
    lidx = '0;
    for (int k = NUM_REGIONS - 1; k >= 0; k--) begin
      if (valid_r[k] && SLOT_BITS'(k) >= i_r) begin
        lfound = 1'b1;
        lidx = SLOT_BITS'(k);
      end
    end
    lmore = 1'b0;
    for (int k = 0; k < NUM_REGIONS; k++) begin
      if (valid_r[k] && SLOT_BITS'(k) > lidx) lmore = 1'b1;
    end
  end

  logic accept;
  assign accept = start && !busy;
  assign busy = (state_r != ST_IDLE);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (action_t'(in_action))
            ACT_ADD: state_nxt = align ? ST_DIVX : ST_FIND;
            ACT_MERGE: state_nxt = ST_PAIR;
            ACT_READ: state_nxt = ST_LIST;
            ACT_CLEAR: state_nxt = ST_IDLE;
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DIVX: if (drsp.done && div_wait_r) state_nxt = ST_DIVW;
      ST_DIVW: if (drsp.done && div_wait_r) state_nxt = ST_DIVY;
      ST_DIVY: if (drsp.done && div_wait_r) state_nxt = ST_DIVH;
      ST_DIVH: if (drsp.done && div_wait_r) state_nxt = ST_FIND;
      ST_FIND: state_nxt = ST_IDLE;
      ST_PAIR: begin
        if (i_r == SLOT_BITS'(NUM_REGIONS - 2) && j_r == SLOT_BITS'(NUM_REGIONS - 1))
          state_nxt = ST_LIST;
      end
      ST_LIST: if (!lfound || !lmore) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Divider requests.
  always_comb begin
    dreq.start = 1'b0;
    dreq.num = ax_r;
    dreq.den = ts_r;
    if (!div_wait_r) begin
      unique case (state_r)
        ST_DIVX: begin dreq.start = 1'b1; dreq.num = ax_r; end
        ST_DIVW: begin dreq.start = 1'b1; dreq.num = aw_r; end
        ST_DIVY: begin dreq.start = 1'b1; dreq.num = ay_r; end
        ST_DIVH: begin dreq.start = 1'b1; dreq.num = ah_r; end
        default: dreq.start = 1'b0;
      endcase
    end
  end

  // Datapath and outputs.
  always_ff @(posedge clk) begin
    out_valid <= 1'b0;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      dirty_pending_r <= 1'b0;
      div_wait_r <= 1'b0;
      sw_r <= 11'd128;
      sh_r <= 11'd64;
      tae_r <= 1'b1;
      ts_r <= 8'd8;
      for (int k = 0; k < NUM_REGIONS; k++) begin
        left_r[k] <= '0;
        top_r[k] <= '0;
        wid_r[k] <= '0;
        hgt_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SW: sw_r <= cfg_data;
          CFG_SH: sh_r <= cfg_data;
          CFG_TAE: tae_r <= cfg_data[0];
          CFG_TS: ts_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (dreq.start) div_wait_r <= 1'b1;
      if (drsp.done) div_wait_r <= 1'b0;
      out_full_merge <= 1'b0;
      out_merged_count <= '0;
      unique case (state_r)
        ST_IDLE: begin
          i_r <= '0;
          j_r <= SLOT_BITS'(1);
          cnt_r <= '0;
          first_r <= 1'b1;
          ax_r <= cx;
          ay_r <= cy;
          aw_r <= cw;
          ah_r <= ch;
          if (accept && action_t'(in_action) == ACT_CLEAR) begin
            valid_r <= '0;
            dirty_pending_r <= 1'b0;
            for (int k = 0; k < NUM_REGIONS; k++) begin
              left_r[k] <= '0;
              top_r[k] <= '0;
              wid_r[k] <= '0;
              hgt_r[k] <= '0;
            end
            out_valid <= 1'b1;
            out_slot <= '0;
            out_rect_x <= '0;
            out_rect_y <= '0;
            out_rect_w <= '0;
            out_rect_h <= '0;
            out_active <= 1'b0;
            out_last <= 1'b1;
          end
        end
        ST_DIVX: if (drsp.done && div_wait_r) begin
          aw_r <= aw_r + ax_r - prod_dn;
          ax_r <= prod_dn;
        end
        ST_DIVW: if (drsp.done && div_wait_r) aw_r <= prod_up;
        ST_DIVY: if (drsp.done && div_wait_r) ay_r <= prod_dn;
        ST_DIVH: if (drsp.done && div_wait_r) ah_r <= prod_up;
        ST_FIND: begin
          dirty_pending_r <= 1'b1;
          out_valid <= 1'b1;
          out_active <= 1'b1;
          out_last <= 1'b1;
          if (found) begin
            left_r[free_idx] <= sat_c(ax_r);
            top_r[free_idx] <= sat_c(ay_r);
            wid_r[free_idx] <= sat_s(aw_r);
            hgt_r[free_idx] <= sat_s(ah_r);
            valid_r[free_idx] <= 1'b1;
            out_slot <= free_idx;
            out_rect_x <= sat_c(ax_r);
            out_rect_y <= sat_c(ay_r);
            out_rect_w <= sat_s(aw_r);
            out_rect_h <= sat_s(ah_r);
          end else begin
            left_r[0] <= sat_c(ux);
            top_r[0] <= sat_c(uy);
            wid_r[0] <= sat_s(ur - ux);
            hgt_r[0] <= sat_s(ub - uy);
            out_slot <= '0;
            out_rect_x <= sat_c(ux);
            out_rect_y <= sat_c(uy);
            out_rect_w <= sat_s(ur - ux);
            out_rect_h <= sat_s(ub - uy);
            out_full_merge <= 1'b1;
          end
        end
        ST_PAIR: begin
          if (ovl) begin
            left_r[i_r] <= (pax < pbx) ? pax[COORD_BITS-1:0] : pbx[COORD_BITS-1:0];
            top_r[i_r] <= (pay < pby) ? pay[COORD_BITS-1:0] : pby[COORD_BITS-1:0];
            wid_r[i_r] <= sat_s(((par > pbr) ? par : pbr) - ((pax < pbx) ? pax : pbx));
            hgt_r[i_r] <= sat_s(((pab > pbb) ? pab : pbb) - ((pay < pby) ? pay : pby));
            valid_r[j_r] <= 1'b0;
            if (cnt_r != 5'd31) cnt_r <= cnt_r + 5'd1;
          end
          if (j_r == SLOT_BITS'(NUM_REGIONS - 1)) begin
            if (i_r == SLOT_BITS'(NUM_REGIONS - 2)) i_r <= '0;
            else begin
              i_r <= i_r + SLOT_BITS'(1);
              j_r <= i_r + SLOT_BITS'(2);
            end
          end else j_r <= j_r + SLOT_BITS'(1);
        end
        ST_LIST: begin
          first_r <= 1'b0;
          out_merged_count <= cnt_r;
          if (lfound) begin
            out_valid <= 1'b1;
            out_slot <= lidx;
            out_rect_x <= left_r[lidx];
            out_rect_y <= top_r[lidx];
            out_rect_w <= wid_r[lidx];
            out_rect_h <= hgt_r[lidx];
            out_active <= 1'b1;
            out_last <= !lmore;
            i_r <= lidx + SLOT_BITS'(1);
          end else begin
            out_valid <= first_r;
            out_slot <= '0;
            out_rect_x <= '0;
            out_rect_y <= '0;
            out_rect_w <= '0;
            out_rect_h <= '0;
            out_active <= 1'b0;
            out_last <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

[rtl/core/drt_divider.sv]
// Shared restoring divider, one quotient bit per cycle.
// Depends on drt_pkg.
module drt_divider (
  input  logic             clk,
  input  logic             rst_n,
  input  drt_pkg::div_req_t req,
  output drt_pkg::div_rsp_t rsp
);
  import drt_pkg::*;

  logic [SEXT_BITS-1:0] q_r, q_nxt;
  logic [8:0] rem_r, rem_nxt;
  logic [7:0] den_r, den_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [8:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = '0;
    if (req.start) begin
      q_nxt = req.num;
      rem_nxt = '0;
      den_nxt = req.den;
      cnt_nxt = 5'(SEXT_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r[7:0], q_r[SEXT_BITS-1]};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[SEXT_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[SEXT_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;
  assign rsp.rem = rem_r[7:0];
endmodule
